// ===== sv/rtkv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtkv_pkg
// Types, constants and digit helpers for the radix trie key/value engine.
// ----------------------------------------------------------------------------
package rtkv_pkg;

  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned LEVELS     = 8;
  localparam int unsigned NODE_COUNT = 256;
  localparam int unsigned SLOTS      = 1 << DIGIT_BITS;
  localparam int unsigned ROW_W      = 2 * SLOTS;
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
  localparam int unsigned SLOT_AW    = NODE_W + DIGIT_BITS;
  localparam int unsigned LVL_W      = $clog2(LEVELS);
  localparam int unsigned FREE_W     = NODE_W + 1;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE           = 2'd0,
    ST_NOT_FOUND      = 2'd1,
    ST_POOL_EXHAUSTED = 2'd2
  } status_e;

  typedef struct packed {
    logic             found;
    logic [LVL_W-1:0] lvl;
  } split_t;

  function automatic logic [DIGIT_BITS-1:0] digit_at(logic [KEY_BITS-1:0] key,
                                                     logic [LVL_W-1:0] lvl);
    logic [KEY_BITS-1:0] sh;
    sh = key >> (DIGIT_BITS * (LEVELS - 1 - int'(lvl)));
    return sh[DIGIT_BITS-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] leaf_bit(logic [DIGIT_BITS-1:0] d);
    return ROW_W'(1) << d;
  endfunction

  function automatic logic [ROW_W-1:0] link_bit(logic [DIGIT_BITS-1:0] d);
    return ROW_W'(1) << (SLOTS + int'(d));
  endfunction

  function automatic split_t first_diff(logic [KEY_BITS-1:0] a,
                                        logic [KEY_BITS-1:0] b,
                                        logic [LVL_W-1:0] from);
    split_t r;
    r.found = 1'b0;
    r.lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (i > int'(from) && digit_at(a, LVL_W'(i)) != digit_at(b, LVL_W'(i))) begin
        r.found = 1'b1;
        r.lvl   = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/rtkv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/radix_trie_key_value_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_trie_key_value_engine
// Key/value store held as an 8-level radix trie of 4-bit digits in a node pool.
// ----------------------------------------------------------------------------
// Pulse start_i while busy_o is low to issue a find, insert or delete. The
// result appears on status_o and found_value_o for exactly one cycle with
// done_o high; it must be taken then. A transaction walks the trie through
// W_RD and W_EV at each level (node row and slot read through registered RAM
// ports). An insert that splits a leaf runs S_POP (and S_POPW for a recycled
// node) and S_LINK per new node, then S_LEAF1 and S_LEAF2 for the leaf pair;
// a delete clears the slot in D_CLR and runs D_RD and D_WT per freed node.
// Each RAM has a single read port. No pass is needed after reset.
module radix_trie_key_value_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] found_value_o
);

  localparam int unsigned NW = rtkv_pkg::NODE_W;
  localparam int unsigned AW = rtkv_pkg::SLOT_AW;
  localparam int unsigned LW = rtkv_pkg::LVL_W;
  localparam int unsigned DW = rtkv_pkg::DIGIT_BITS;
  localparam int unsigned RW = rtkv_pkg::ROW_W;
  localparam int unsigned FW = rtkv_pkg::FREE_W;

  typedef enum logic [3:0] {
    IDLE, W_RD, W_EV, S_POP, S_POPW, S_LINK, S_LEAF1, S_LEAF2, D_CLR, D_RD, D_WT
  } state_e;

  state_e                  state_q;
  rtkv_pkg::opcode_e       op_q;
  logic [31:0]             key_q, val_q, okey_q, oval_q;
  logic [NW-1:0]           node_q, nn_q, rtop_q;
  logic [LW-1:0]           lvl_q, lv_q, dlev_q;
  logic [DW-1:0]           dc_q;
  logic [RW-1:0]           rowv_q;
  logic [NW-1:0]           path_q [rtkv_pkg::LEVELS];
  logic [FW-1:0]           fresh_q;
  logic                    root_valid_q;
  logic                    done_q;
  rtkv_pkg::status_e       status_q;
  logic [31:0]             fv_q;

  logic          row_we, key_we, data_we, free_we;
  logic [NW-1:0] row_waddr, row_raddr, free_waddr, free_raddr, free_wdata, free_rdata;
  logic [RW-1:0] row_wdata, row_rdata, row_in, row_clr;
  logic [AW-1:0] slot_waddr, slot_raddr;
  logic [31:0]   key_wdata, data_wdata, key_rdata, data_rdata;
  logic [DW-1:0] cur_dig, dk, dold, dn_dig;
  logic [LW-1:0] lvl_dn;
  logic          is_leaf, is_link, key_eq, del_more;
  logic [FW-1:0] free_cnt, need;
  rtkv_pkg::split_t split;

  assign row_in   = (node_q == '0 && !root_valid_q) ? '0 : row_rdata;
  assign cur_dig  = rtkv_pkg::digit_at(key_q, lvl_q);
  assign is_leaf  = row_in[cur_dig];
  assign is_link  = row_in[rtkv_pkg::SLOTS + int'(cur_dig)];
  assign key_eq   = key_rdata == key_q;
  assign split    = rtkv_pkg::first_diff(key_q, key_rdata, lvl_q);
  assign free_cnt = FW'(rtop_q) + (FW'(rtkv_pkg::NODE_COUNT) - fresh_q);
  assign need     = FW'(split.lvl) - FW'(lvl_q);
  assign dk       = rtkv_pkg::digit_at(key_q, lv_q);
  assign dold     = rtkv_pkg::digit_at(okey_q, lv_q);
  assign lvl_dn   = lvl_q - LW'(1);
  assign dn_dig   = rtkv_pkg::digit_at(key_q, lvl_dn);
  assign row_clr  = rowv_q & ~(rtkv_pkg::leaf_bit(dc_q) | rtkv_pkg::link_bit(dc_q));
  assign del_more = node_q != '0 && row_clr == '0 && lvl_q != '0;

  always_comb begin
    row_we     = 1'b0;
    row_waddr  = node_q;
    row_wdata  = '0;
    row_raddr  = node_q;
    key_we     = 1'b0;
    data_we    = 1'b0;
    slot_waddr = {node_q, cur_dig};
    slot_raddr = {node_q, cur_dig};
    key_wdata  = key_q;
    data_wdata = val_q;
    free_we    = 1'b0;
    free_waddr = rtop_q;
    free_wdata = node_q;
    free_raddr = rtop_q - NW'(1);
    unique case (state_q)
      W_EV: begin
        if (op_q == rtkv_pkg::OP_INSERT) begin
          if (is_leaf && key_eq) begin
            data_we = 1'b1;
          end else if (!is_leaf && !is_link) begin
            row_we    = 1'b1;
            row_wdata = row_in | rtkv_pkg::leaf_bit(cur_dig);
            key_we    = 1'b1;
            data_we   = 1'b1;
          end
        end
      end
      S_LINK: begin
        row_we     = 1'b1;
        row_wdata  = (rowv_q & ~rtkv_pkg::leaf_bit(dc_q)) | rtkv_pkg::link_bit(dc_q);
        data_we    = 1'b1;
        slot_waddr = {node_q, dc_q};
        data_wdata = 32'(nn_q);
      end
      S_LEAF1: begin
        row_we     = 1'b1;
        row_waddr  = nn_q;
        row_wdata  = rtkv_pkg::leaf_bit(dk) | rtkv_pkg::leaf_bit(dold);
        key_we     = 1'b1;
        data_we    = 1'b1;
        slot_waddr = {nn_q, dk};
      end
      S_LEAF2: begin
        key_we     = 1'b1;
        data_we    = 1'b1;
        slot_waddr = {nn_q, dold};
        key_wdata  = okey_q;
        data_wdata = oval_q;
      end
      D_CLR: begin
        row_we    = 1'b1;
        row_wdata = row_clr;
        free_we   = del_more;
      end
      default: begin
      end
    endcase
  end

  rtkv_ram #(.WIDTH(RW), .DEPTH(rtkv_pkg::NODE_COUNT)) u_row_ram (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .raddr_i(row_raddr), .rdata_o(row_rdata)
  );

  rtkv_ram #(.WIDTH(32), .DEPTH(rtkv_pkg::NODE_COUNT * rtkv_pkg::SLOTS)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(slot_waddr), .wdata_i(key_wdata),
    .raddr_i(slot_raddr), .rdata_o(key_rdata)
  );

  rtkv_ram #(.WIDTH(32), .DEPTH(rtkv_pkg::NODE_COUNT * rtkv_pkg::SLOTS)) u_data_ram (
    .clk_i, .we_i(data_we), .waddr_i(slot_waddr), .wdata_i(data_wdata),
    .raddr_i(slot_raddr), .rdata_o(data_rdata)
  );

  rtkv_ram #(.WIDTH(NW), .DEPTH(rtkv_pkg::NODE_COUNT)) u_free_ram (
    .clk_i, .we_i(free_we), .waddr_i(free_waddr), .wdata_i(free_wdata),
    .raddr_i(free_raddr), .rdata_o(free_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      op_q         <= rtkv_pkg::OP_FIND;
      key_q        <= '0;
      val_q        <= '0;
      okey_q       <= '0;
      oval_q       <= '0;
      node_q       <= '0;
      nn_q         <= '0;
      rtop_q       <= '0;
      lvl_q        <= '0;
      lv_q         <= '0;
      dlev_q       <= '0;
      dc_q         <= '0;
      rowv_q       <= '0;
      path_q       <= '{default: '0};
      fresh_q      <= FW'(1);
      root_valid_q <= 1'b0;
      done_q       <= 1'b0;
      status_q     <= rtkv_pkg::ST_DONE;
      fv_q         <= '0;
    end else begin
      done_q <= 1'b0;
      if (row_we && row_waddr == '0) begin
        root_valid_q <= 1'b1;
      end
      unique case (state_q)
        IDLE: begin
          if (start_i) begin
            op_q   <= rtkv_pkg::opcode_e'(opcode_i);
            key_q  <= key_i;
            val_q  <= value_i;
            node_q <= '0;
            lvl_q  <= '0;
            if (rtkv_pkg::opcode_e'(opcode_i) == rtkv_pkg::OP_UNUSED) begin
              done_q   <= 1'b1;
              status_q <= rtkv_pkg::ST_NOT_FOUND;
              fv_q     <= '0;
            end else begin
              state_q <= W_RD;
            end
          end
        end
        W_RD: begin
          path_q[lvl_q] <= node_q;
          state_q       <= W_EV;
        end
        W_EV: begin
          rowv_q <= row_in;
          okey_q <= key_rdata;
          oval_q <= data_rdata;
          dc_q   <= cur_dig;
          fv_q   <= '0;
          if (is_leaf) begin
            unique case (op_q)
              rtkv_pkg::OP_FIND: begin
                done_q   <= 1'b1;
                state_q  <= IDLE;
                status_q <= key_eq ? rtkv_pkg::ST_DONE : rtkv_pkg::ST_NOT_FOUND;
                fv_q     <= key_eq ? data_rdata : '0;
              end
              rtkv_pkg::OP_INSERT: begin
                if (key_eq) begin
                  done_q   <= 1'b1;
                  state_q  <= IDLE;
                  status_q <= rtkv_pkg::ST_DONE;
                end else if (!split.found || need > free_cnt) begin
                  done_q   <= 1'b1;
                  state_q  <= IDLE;
                  status_q <= rtkv_pkg::ST_POOL_EXHAUSTED;
                end else begin
                  lv_q    <= lvl_q + LW'(1);
                  dlev_q  <= split.lvl;
                  state_q <= S_POP;
                end
              end
              rtkv_pkg::OP_DELETE: begin
                if (key_eq) begin
                  state_q <= D_CLR;
                end else begin
                  done_q   <= 1'b1;
                  state_q  <= IDLE;
                  status_q <= rtkv_pkg::ST_NOT_FOUND;
                end
              end
              default: begin
                done_q   <= 1'b1;
                state_q  <= IDLE;
                status_q <= rtkv_pkg::ST_NOT_FOUND;
              end
            endcase
          end else if (is_link) begin
            if (lvl_q == LW'(rtkv_pkg::LEVELS - 1)) begin
              done_q   <= 1'b1;
              state_q  <= IDLE;
              status_q <= (op_q == rtkv_pkg::OP_INSERT) ? rtkv_pkg::ST_POOL_EXHAUSTED
                                                        : rtkv_pkg::ST_NOT_FOUND;
            end else begin
              node_q  <= data_rdata[NW-1:0];
              lvl_q   <= lvl_q + LW'(1);
              state_q <= W_RD;
            end
          end else begin
            done_q   <= 1'b1;
            state_q  <= IDLE;
            status_q <= (op_q == rtkv_pkg::OP_INSERT) ? rtkv_pkg::ST_DONE
                                                      : rtkv_pkg::ST_NOT_FOUND;
          end
        end
        S_POP: begin
          if (rtop_q != '0) begin
            rtop_q  <= rtop_q - NW'(1);
            state_q <= S_POPW;
          end else begin
            nn_q    <= fresh_q[NW-1:0];
            fresh_q <= fresh_q + FW'(1);
            state_q <= S_LINK;
          end
        end
        S_POPW: begin
          nn_q    <= free_rdata;
          state_q <= S_LINK;
        end
        S_LINK: begin
          if (lv_q == dlev_q) begin
            state_q <= S_LEAF1;
          end else begin
            node_q  <= nn_q;
            dc_q    <= dk;
            rowv_q  <= '0;
            lv_q    <= lv_q + LW'(1);
            state_q <= S_POP;
          end
        end
        S_LEAF1: begin
          state_q <= S_LEAF2;
        end
        S_LEAF2: begin
          done_q   <= 1'b1;
          state_q  <= IDLE;
          status_q <= rtkv_pkg::ST_DONE;
        end
        D_CLR: begin
          if (del_more) begin
            rtop_q  <= rtop_q + NW'(1);
            lvl_q   <= lvl_dn;
            node_q  <= path_q[lvl_dn];
            dc_q    <= dn_dig;
            state_q <= D_RD;
          end else begin
            done_q   <= 1'b1;
            state_q  <= IDLE;
            status_q <= rtkv_pkg::ST_DONE;
          end
        end
        D_RD: begin
          state_q <= D_WT;
        end
        D_WT: begin
          rowv_q  <= row_in;
          state_q <= D_CLR;
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign busy_o        = state_q != IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = fv_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == IDLE)
    else $error("result strobe outside idle");

  a_fresh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q >= FW'(1) && fresh_q <= FW'(rtkv_pkg::NODE_COUNT))
    else $error("fresh node counter out of range");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(rtop_q) < fresh_q)
    else $error("recycled node stack deeper than nodes handed out");

  a_exhaust_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q == rtkv_pkg::ST_POOL_EXHAUSTED |-> op_q == rtkv_pkg::OP_INSERT)
    else $error("pool exhausted reported for non-insert");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && opcode_i != rtkv_pkg::OP_UNUSED |=> busy_o)
    else $error("accepted transaction did not start a walk");

  a_find_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q != rtkv_pkg::ST_DONE |-> fv_q == '0)
    else $error("nonzero value on failed transaction");

endmodule
